// ----- hw/rtl/rvalu_pkg.sv -----
// ----------------------------------------------------------------------------
// rvalu_pkg
// Shared types and constants for the RV32I register ALU execute block:
// opcodes, ALU function codes, status codes and inter-module records.
// ----------------------------------------------------------------------------
package rvalu_pkg;

   // default register file depth
   localparam int RVALU_REGISTER_COUNT = 32;

   localparam int XLEN      = 32;
   localparam int REG_IDX_W = 5;

   // major opcodes, all seven bits
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_BRANCH = 7'h63;

   // funct3 codes of the integer alu
   typedef enum logic [2:0] {
      F3_ADD  = 3'd0,
      F3_SLL  = 3'd1,
      F3_SLT  = 3'd2,
      F3_SLTU = 3'd3,
      F3_XOR  = 3'd4,
      F3_SR   = 3'd5,
      F3_OR   = 3'd6,
      F3_AND  = 3'd7
   } funct3_type;

   // result status
   typedef enum logic [1:0] {
      ST_EXECUTED   = 2'd0,
      ST_RECOGNISED = 2'd1,
      ST_ILLEGAL    = 2'd2
   } status_type;

   // register file write port
   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [XLEN-1:0]      data;
   } wr_port_type;

   // one result item
   typedef struct packed {
      logic                 wrote;
      logic [XLEN-1:0]      dest_value;
      logic [REG_IDX_W-1:0] dest_index;
      status_type           status;
   } result_type;

endpackage

// ----- hw/rtl/rvalu_regfile.sv -----
// ----------------------------------------------------------------------------
// rvalu_regfile
// Integer register file with two registered read ports, one write port,
// per-entry valid bits for the zero reset, and forwarding of a write that
// lands on the same edge as the read.
// ----------------------------------------------------------------------------
module rvalu_regfile #(
   parameter int REGISTER_COUNT = rvalu_pkg::RVALU_REGISTER_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [rvalu_pkg::REG_IDX_W-1:0]     rs1_idx,
   input  logic [rvalu_pkg::REG_IDX_W-1:0]     rs2_idx,
   input  rvalu_pkg::wr_port_type              wr,
   output logic [rvalu_pkg::XLEN-1:0]          rs1_data,
   output logic [rvalu_pkg::XLEN-1:0]          rs2_data
);
   import rvalu_pkg::*;

   localparam int ADDR_W = $clog2(REGISTER_COUNT);
   localparam logic [REG_IDX_W-1:0] LAST_IDX = REG_IDX_W'(REGISTER_COUNT - 1);

   logic [XLEN-1:0]           mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] valid_ff;

   logic [XLEN-1:0] rdata1_ff, rdata2_ff;
   logic            ok1_ff, ok2_ff, ok1_in, ok2_in;
   logic            fwd1_ff, fwd2_ff, fwd1_in, fwd2_in;
   logic [XLEN-1:0] wb_data_ff;
   logic            wr_hit;

   // a write goes to a real register other than x0
   assign wr_hit = wr.en && (wr.idx != '0) && (wr.idx <= LAST_IDX);

   // readable entry: not x0, inside the file, written since reset
   assign ok1_in = (rs1_idx != '0) && (rs1_idx <= LAST_IDX) && valid_ff[rs1_idx[ADDR_W-1:0]];
   assign ok2_in = (rs2_idx != '0) && (rs2_idx <= LAST_IDX) && valid_ff[rs2_idx[ADDR_W-1:0]];

   // write on the same edge as the read wins
   assign fwd1_in = wr_hit && (wr.idx == rs1_idx);
   assign fwd2_in = wr_hit && (wr.idx == rs2_idx);

   // storage array
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[wr.idx[ADDR_W-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rdata1_ff <= mem[rs1_idx[ADDR_W-1:0]];
         rdata2_ff <= mem[rs2_idx[ADDR_W-1:0]];
      end
      if (wr_hit) begin
         wb_data_ff <= wr.data;
      end
   end

   // valid bits and read flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ok1_ff   <= 1'b0;
         ok2_ff   <= 1'b0;
         fwd1_ff  <= 1'b0;
         fwd2_ff  <= 1'b0;
      end else begin
         if (wr_hit) begin
            valid_ff[wr.idx[ADDR_W-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            ok1_ff  <= ok1_in;
            ok2_ff  <= ok2_in;
            fwd1_ff <= fwd1_in;
            fwd2_ff <= fwd2_in;
         end
      end
   end

   // operand selection
   assign rs1_data = fwd1_ff ? wb_data_ff : (ok1_ff ? rdata1_ff : '0);
   assign rs2_data = fwd2_ff ? wb_data_ff : (ok2_ff ? rdata2_ff : '0);

endmodule

// ----- hw/rtl/rvalu_execute.sv -----
// ----------------------------------------------------------------------------
// rvalu_execute
// Decode of one RV32I instruction word and the integer alu for OP and
// OP-IMM, giving status, destination, value and write flag.
// ----------------------------------------------------------------------------
module rvalu_execute #(
   parameter int REGISTER_COUNT = rvalu_pkg::RVALU_REGISTER_COUNT
) (
   input  logic [rvalu_pkg::XLEN-1:0] instruction,
   input  logic [rvalu_pkg::XLEN-1:0] rs1_data,
   input  logic [rvalu_pkg::XLEN-1:0] rs2_data,
   output rvalu_pkg::result_type      result
);
   import rvalu_pkg::*;

   localparam logic [REG_IDX_W-1:0] LAST_IDX = REG_IDX_W'(REGISTER_COUNT - 1);

   logic [6:0]           opcode;
   logic [REG_IDX_W-1:0] rd;
   funct3_type           f3;
   logic                 alt;
   logic [XLEN-1:0]      imm;
   logic [XLEN-1:0]      op_a, op_b, alu_out;
   logic [4:0]           shamt;
   logic                 is_op, is_alu;

   // field extraction
   assign opcode = instruction[6:0];
   assign rd     = instruction[11:7];
   assign f3     = funct3_type'(instruction[14:12]);
   assign alt    = instruction[30];
   assign imm    = {{(XLEN-12){instruction[31]}}, instruction[31:20]};
   assign is_op  = (opcode == OPC_OP);
   assign is_alu = is_op || (opcode == OPC_OP_IMM);

   assign op_a  = rs1_data;
   assign op_b  = is_op ? rs2_data : imm;
   assign shamt = op_b[4:0];

   // integer alu
   always_comb begin
      unique case (f3)
         F3_ADD:  alu_out = (alt && is_op) ? (op_a - op_b) : (op_a + op_b);
         F3_SLL:  alu_out = op_a << shamt;
         F3_SLT:  alu_out = XLEN'($signed(op_a) < $signed(op_b));
         F3_SLTU: alu_out = XLEN'(op_a < op_b);
         F3_XOR:  alu_out = op_a ^ op_b;
         F3_SR:   alu_out = alt ? XLEN'($signed(op_a) >>> shamt) : (op_a >> shamt);
         F3_OR:   alu_out = op_a | op_b;
         F3_AND:  alu_out = op_a & op_b;
         default: alu_out = '0;
      endcase
   end

   // status and write-back decision
   always_comb begin
      result.dest_index = rd;
      result.dest_value = '0;
      result.wrote      = 1'b0;
      priority if (is_alu) begin
         result.status     = ST_EXECUTED;
         result.dest_value = alu_out;
         result.wrote      = (rd != '0) && (rd <= LAST_IDX);
      end else if ((opcode == OPC_LUI) || (opcode == OPC_BRANCH) ||
                   (opcode == OPC_LOAD) || (opcode == OPC_STORE)) begin
         result.status = ST_RECOGNISED;
      end else begin
         result.status = ST_ILLEGAL;
      end
   end

endmodule

// ----- hw/rtl/rv32i_register_alu_execute.sv -----
// A request transfer loads the operand stage (instruction, registered reads);
// as that stage advances, the result register loads and rsp_tvalid rises.
// Throughput: one instruction per cycle unless rsp_tready stalls the result
// register; alu and register write-back lie between the operand stage and it.
// Reset (synchronous, active high) empties both stages and marks every
// register as zero through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// rv32i_register_alu_execute
// Top level: request stage with registered register-file reads, alu with
// write-back, and a result register on the response stream.
// ----------------------------------------------------------------------------
module rv32i_register_alu_execute #(
   parameter int REGISTER_COUNT = rvalu_pkg::RVALU_REGISTER_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instruction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [1:0] status, [6:2] dest_index,
                                    // [38:7] dest_value, [39] wrote
);
   import rvalu_pkg::*;

   logic            req_xfer;
   logic            s1_valid_ff, s1_valid_in;
   logic [XLEN-1:0] s1_instr_ff;
   logic            s1_advance;
   logic            out_valid_ff, out_valid_in;
   result_type      out_ff;
   result_type      exe_result;
   wr_port_type     wr;
   logic [XLEN-1:0] rs1_data, rs2_data;

   // handshake
   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !s1_advance);
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_tready);

   // register file
   assign wr.en   = s1_advance && exe_result.wrote;
   assign wr.idx  = exe_result.dest_index;
   assign wr.data = exe_result.dest_value;

   rvalu_regfile #(
      .REGISTER_COUNT (REGISTER_COUNT)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_xfer),
      .rs1_idx  (req_tdata[19:15]),
      .rs2_idx  (req_tdata[24:20]),
      .wr       (wr),
      .rs1_data (rs1_data),
      .rs2_data (rs2_data)
   );

   // decode and alu
   rvalu_execute #(
      .REGISTER_COUNT (REGISTER_COUNT)
   ) u_execute (
      .instruction (s1_instr_ff),
      .rs1_data    (rs1_data),
      .rs2_data    (rs2_data),
      .result      (exe_result)
   );

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_instr_ff <= req_tdata;
      end
      if (s1_advance) begin
         out_ff <= exe_result;
      end
   end

   // response stream
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.wrote, out_ff.dest_value, out_ff.dest_index, out_ff.status};

endmodule

// ----- tb/rv32i_register_alu_execute_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_register_alu_execute_tb
// Self-checking bench for the RV32I register ALU execute block. Instruction
// words go in on the req stream in random bursts while the rsp stream stalls
// on its own pattern. A mirror of the register file computes the status,
// rd, value and write flag of every instruction, and each rsp transfer is
// compared field by field with the oldest pending entry.
// ----------------------------------------------------------------------------
module rv32i_register_alu_execute_tb;
   import rvalu_pkg::*;

   localparam int REG_COUNT     = RVALU_REGISTER_COUNT;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 600;
   localparam int SETTLE_CYCLES = 8;

   // opcodes outside the executed and recognised sets
   localparam logic [6:0] OPC_OP_32     = 7'h3B;
   localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;

   // receiver stall patterns
   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG_STALL} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] instruction
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [1:0] status, [6:2] dest_index,
                                   // [38:7] dest_value, [39] wrote

   logic [31:0] shadow_gpr [REG_COUNT];
   result_type  pending_results [$];
   logic [6:0]  recognised_opcodes [4] = '{OPC_LUI, OPC_BRANCH, OPC_LOAD, OPC_STORE};

   int          errors       = 0;
   int          items_sent   = 0;
   int          n_results    = 0;
   int          n_executed   = 0;
   int          n_recognised = 0;
   int          n_illegal    = 0;
   int          n_writes     = 0;
   int          burst_left   = 0;
   int          idle_cycles  = 0;
   rx_mode_type rx_mode      = RX_OPEN;
   int          rx_mode_left = 0;
   int          rx_phase     = 0;
   int          rx_hold_left = 0;
   logic        rx_hold_ready = 1'b1;

   rv32i_register_alu_execute #(
      .REGISTER_COUNT(REG_COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // register file mirror, all zero after reset
   initial begin
      foreach (shadow_gpr[i]) shadow_gpr[i] = '0;
   end

   function automatic logic [31:0] gpr_read(input logic [4:0] idx);
      if (idx == 5'd0 || idx >= REG_COUNT) return '0;
      return shadow_gpr[idx];
   endfunction

   // execute one instruction on the mirror and return its result
   function automatic result_type alu_writeback(input logic [31:0] word);
      result_type  res;
      logic [6:0]  opcode;
      logic [4:0]  rd;
      logic [4:0]  shamt;
      logic [31:0] a;
      logic [31:0] b;
      logic        alt;
      opcode = word[6:0];
      rd     = word[11:7];
      alt    = word[30];
      res    = '0;
      res.dest_index = rd;
      if (opcode == OPC_OP || opcode == OPC_OP_IMM) begin
         a     = gpr_read(word[19:15]);
         b     = (opcode == OPC_OP) ? gpr_read(word[24:20])
                                    : {{20{word[31]}}, word[31:20]};
         shamt = b[4:0];
         case (funct3_type'(word[14:12]))
            F3_ADD:  res.dest_value = (alt && opcode == OPC_OP) ? a - b : a + b;
            F3_SLL:  res.dest_value = a << shamt;
            F3_SLT:  res.dest_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: res.dest_value = (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  res.dest_value = a ^ b;
            F3_SR: begin
               if (alt) begin
                  res.dest_value = $signed(a) >>> shamt;
               end else begin
                  res.dest_value = a >> shamt;
               end
            end
            F3_OR:   res.dest_value = a | b;
            default: res.dest_value = a & b;
         endcase
         res.status = ST_EXECUTED;
         // x0 and indices beyond the file are never written
         if (rd != 5'd0 && rd < REG_COUNT) begin
            shadow_gpr[rd] = res.dest_value;
            res.wrote      = 1'b1;
         end
      end else if (opcode inside {OPC_LUI, OPC_BRANCH, OPC_LOAD, OPC_STORE}) begin
         res.status = ST_RECOGNISED;
      end else begin
         res.status = ST_ILLEGAL;
      end
      return res;
   endfunction

   function automatic logic [31:0] encode(input logic [11:0] upper, input logic [4:0] rs1,
                                          input funct3_type f3, input logic [4:0] rd,
                                          input logic [6:0] opcode);
      return {upper, rs1, f3, rd, opcode};
   endfunction

   // one req transfer, with a random gap at the start of each burst
   task automatic send_instruction(input logic [31:0] word);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(alu_writeback(word));
      items_sent++;
   endtask

   task automatic release_request();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // largest positive and negative immediates
   task automatic test_immediate_extremes();
      send_instruction(encode(12'h7FF, 5'd0, F3_ADD, 5'd1, OPC_OP_IMM));
      send_instruction(encode(12'h800, 5'd0, F3_ADD, 5'd2, OPC_OP_IMM));
   endtask

   // every funct3 in register and immediate form, sub and sra included
   task automatic test_each_operation();
      logic [11:0] imm;
      for (int f = 0; f < 8; f++) begin
         // rs1 = x2 (negative), rs2 = x1 whose low bits give a shift of 31
         send_instruction(encode({7'b0000000, 5'd1}, 5'd2, funct3_type'(f),
                                 5'(8 + f), OPC_OP));
      end
      send_instruction(encode({7'b0100000, 5'd1}, 5'd2, F3_ADD, 5'd16, OPC_OP));
      send_instruction(encode({7'b0100000, 5'd1}, 5'd2, F3_SR, 5'd17, OPC_OP));
      for (int f = 0; f < 8; f++) begin
         case (funct3_type'(f))
            F3_SLL:  imm = 12'h000;
            F3_SR:   imm = 12'h41F;
            default: imm = 12'hFFF;
         endcase
         send_instruction(encode(imm, 5'd2, funct3_type'(f), 5'(20 + f), OPC_OP_IMM));
      end
   endtask

   // x0 destination, ignored funct7 bits, recognised and near-miss opcodes
   task automatic test_special_cases();
      logic [31:0] word;
      send_instruction(encode(12'h7FF, 5'd1, F3_ADD, 5'd0, OPC_OP_IMM));
      send_instruction(encode({7'b1011111, 5'd2}, 5'd1, F3_ADD, 5'd29, OPC_OP));
      foreach (recognised_opcodes[i]) begin
         word      = $urandom();
         word[6:0] = recognised_opcodes[i];
         send_instruction(word);
      end
      send_instruction(encode(12'h000, 5'd1, F3_ADD, 5'd30, OPC_OP_32));
   endtask

   // mostly well-formed alu code with random content, some noise
   task automatic test_random_programs(input int count);
      logic [31:0] word;
      int          pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         word = $urandom();
         if (pick < 75) begin
            word[6:0] = $urandom_range(0, 1) ? OPC_OP : OPC_OP_IMM;
            // short dependency chains through a handful of registers
            if ($urandom_range(0, 3) != 0) begin
               word[11:7]  = 5'($urandom_range(1, 6));
               word[19:15] = 5'($urandom_range(0, 6));
               word[24:20] = 5'($urandom_range(0, 6));
            end
            if (word[6:0] == OPC_OP_IMM && $urandom_range(0, 4) == 0) begin
               case ($urandom_range(0, 3))
                  0:       word[31:20] = 12'h000;
                  1:       word[31:20] = 12'h7FF;
                  2:       word[31:20] = 12'h800;
                  default: word[31:20] = 12'hFFF;
               endcase
            end
         end else if (pick < 85) begin
            word[6:0] = recognised_opcodes[$urandom_range(0, 3)];
         end else if (pick < 90) begin
            word[6:0] = $urandom_range(0, 1) ? OPC_OP_32 : OPC_OP_IMM_32;
         end
         // anything else stays a raw word, nearly always an illegal opcode
         send_instruction(word);
      end
   endtask

   // sender holds off until every outstanding result has come back
   task automatic test_drain_pause();
      test_random_programs(20);
      release_request();
      wait_for_drain();
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
         RX_OPEN:     rsp_tready <= 1'b1;
         RX_RANDOM:   rsp_tready <= ($urandom_range(0, 9) < 6);
         RX_PERIODIC: rsp_tready <= (rx_phase % 4 != 3);
         default: begin
            if (rx_hold_left == 0) begin
               rx_hold_ready = !rx_hold_ready;
               rx_hold_left  = rx_hold_ready ? $urandom_range(1, 6) : $urandom_range(5, 24);
            end
            rx_hold_left--;
            rsp_tready <= rx_hold_ready;
         end
      endcase
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata);
         n_results++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
            check_field("dest_value", want.dest_value, got.dest_value);
            check_field("wrote", 32'(want.wrote), 32'(got.wrote));
            case (want.status)
               ST_EXECUTED:   n_executed++;
               ST_RECOGNISED: n_recognised++;
               default:       n_illegal++;
            endcase
            if (want.wrote) n_writes++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // test sequence
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_immediate_extremes();
      test_each_operation();
      test_special_cases();
      test_random_programs(RANDOM_ITEMS);
      test_drain_pause();
      test_random_programs(RANDOM_ITEMS);

      release_request();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d instructions and %0d results: %0d executed, %0d recognised,",
               items_sent, n_results, n_executed, n_recognised);
      $display("%0d illegal, %0d register writes, with random sender gaps and receiver stalls",
               n_illegal, n_writes);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived", errors, pending_results.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
